>>> hdl/scba_pkg.sv
// Shared types, constants and helpers for the size-class buffer allocator.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

  // Field widths
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned GSIZE_W = 15;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned CNT_W   = 11;

  localparam int unsigned NUM_CLASSES = 4;

  // Default pool sizes per class
  localparam int unsigned POOL_2K_DEF  = 1024;
  localparam int unsigned POOL_4K_DEF  = 128;
  localparam int unsigned POOL_8K_DEF  = 64;
  localparam int unsigned POOL_16K_DEF = 32;

  // Class size limits in bytes
  localparam logic [SIZE_W-1:0] LIMIT_2K  = 16'd2048;
  localparam logic [SIZE_W-1:0] LIMIT_4K  = 16'd4096;
  localparam logic [SIZE_W-1:0] LIMIT_8K  = 16'd8192;
  localparam logic [SIZE_W-1:0] LIMIT_16K = 16'd16384;

  // Byte size of the smallest class; larger classes double it
  localparam logic [GSIZE_W-1:0] BASE_SIZE = 15'd2048;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_FREED    = 3'd3,
    ST_REJECTED = 3'd4
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  // Classified request handed from front to back
  typedef struct packed {
    op_e              op;
    logic             too_big;
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Address bits needed for a store of the given depth
  function automatic int unsigned addr_width(input int unsigned depth);
    int unsigned w;
    w = (depth > 1) ? $clog2(depth) : 1;
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/scba_req_if.sv
// Request channel: operation, byte size and index being freed.
`timescale 1ns / 1ps
`default_nettype none

interface scba_req_if;
  logic                            valid;
  logic                            ready;
  scba_pkg::op_e                   op;
  logic [scba_pkg::SIZE_W-1:0]     req_size;
  logic [scba_pkg::IDX_W-1:0]      buf_index;

  modport source (output valid, op, req_size, buf_index, input ready);
  modport sink   (input valid, op, req_size, buf_index, output ready);
endinterface

`default_nettype wire

>>> hdl/scba_rsp_if.sv
// Response channel: status, granted size, index, class and in-use count.
`timescale 1ns / 1ps
`default_nettype none

interface scba_rsp_if;
  logic                            valid;
  logic                            ready;
  scba_pkg::status_e               status;
  logic [scba_pkg::GSIZE_W-1:0]    granted_size;
  logic [scba_pkg::IDX_W-1:0]      out_index;
  logic [scba_pkg::CLS_W-1:0]      size_class;
  logic [scba_pkg::CNT_W-1:0]      used_count;

  modport source (output valid, status, granted_size, out_index, size_class, used_count,
                  input ready);
  modport sink   (input valid, status, granted_size, out_index, size_class, used_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/scba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scba_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = scba_pkg::addr_width(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/scba_front.sv
// Front end: accept requests, pick the size class and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module scba_front (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  scba_req_if.sink     req_i,
  output logic         cmd_valid_o,
  input  wire logic    cmd_ready_i,
  output scba_pkg::cmd_t cmd_o
);

  localparam int unsigned QD  = scba_pkg::QUEUE_DEPTH;
  localparam int unsigned PW  = scba_pkg::addr_width(QD);
  localparam int unsigned CW  = $clog2(QD + 1);

  scba_pkg::cmd_t cls_cmd;
  scba_pkg::cmd_t entry_q [QD];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           push, pop;

  // Classify the request by size
  always_comb begin
    cls_cmd.op      = req_i.op;
    cls_cmd.idx     = req_i.buf_index;
    cls_cmd.too_big = 1'b0;
    if (req_i.req_size inside {[16'd0 : scba_pkg::LIMIT_2K]}) begin
      cls_cmd.cls = 2'd0;
    end else if (req_i.req_size inside {[16'd0 : scba_pkg::LIMIT_4K]}) begin
      cls_cmd.cls = 2'd1;
    end else if (req_i.req_size inside {[16'd0 : scba_pkg::LIMIT_8K]}) begin
      cls_cmd.cls = 2'd2;
    end else if (req_i.req_size inside {[16'd0 : scba_pkg::LIMIT_16K]}) begin
      cls_cmd.cls = 2'd3;
    end else begin
      cls_cmd.cls     = 2'd0;
      cls_cmd.too_big = 1'b1;
    end
  end

  // Queue handshakes
  assign req_i.ready = (count_q != CW'(QD));
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified request
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

>>> hdl/scba_back.sv
// Back end: free stacks per class, free counts, and the registered response.
`timescale 1ns / 1ps
`default_nettype none

module scba_back #(
  parameter int unsigned POOL_2K  = scba_pkg::POOL_2K_DEF,
  parameter int unsigned POOL_4K  = scba_pkg::POOL_4K_DEF,
  parameter int unsigned POOL_8K  = scba_pkg::POOL_8K_DEF,
  parameter int unsigned POOL_16K = scba_pkg::POOL_16K_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire scba_pkg::cmd_t  cmd_i,
  scba_rsp_if.source           rsp_o
);

  localparam int unsigned CW  = scba_pkg::CNT_W;
  localparam int unsigned IW  = scba_pkg::IDX_W;
  localparam int unsigned GW  = scba_pkg::GSIZE_W;
  localparam int unsigned LW  = scba_pkg::CLS_W;
  localparam int unsigned NC  = scba_pkg::NUM_CLASSES;

  localparam logic [NC-1:0][CW-1:0] POOL_SIZE = {
    CW'(POOL_16K), CW'(POOL_8K), CW'(POOL_4K), CW'(POOL_2K)
  };

  scba_pkg::back_state_e state_q, state_d;

  logic [CW-1:0] free_cnt_q [NC];
  logic [CW-1:0] free_cnt_d [NC];
  // Lowest free count seen: stack slots below it still hold their reset index
  logic [CW-1:0] low_q [NC];
  logic [CW-1:0] low_d [NC];

  logic [LW-1:0] pend_cls_q, pend_cls_d;
  logic          pend_mem_q, pend_mem_d;
  logic [IW-1:0] pend_addr_q, pend_addr_d;
  logic [CW-1:0] pend_used_q, pend_used_d;

  logic              rsp_valid_q, rsp_valid_d;
  scba_pkg::status_e rsp_status_q, rsp_status_d;
  logic [GW-1:0]     rsp_gsize_q, rsp_gsize_d;
  logic [IW-1:0]     rsp_index_q, rsp_index_d;
  logic [LW-1:0]     rsp_class_q, rsp_class_d;
  logic [CW-1:0]     rsp_used_q, rsp_used_d;

  logic [NC-1:0] ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  logic [IW-1:0] ram_rdata [NC];

  logic          out_free;
  logic          fire;
  logic [CW-1:0] cnt;
  logic [CW-1:0] pool;
  logic [CW-1:0] pop_pos;
  logic [CW-1:0] push_cnt;
  logic          grant;

  // Per-class stack storage
  for (genvar g = 0; g < NC; g++) begin : g_stack
    localparam int unsigned DEPTH = POOL_SIZE[g];
    localparam int unsigned AW    = scba_pkg::addr_width(DEPTH);
    scba_ram #(
      .WIDTH (IW),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr[AW-1:0]),
      .wdata_i (cmd_i.idx),
      .raddr_i (ram_raddr[AW-1:0]),
      .rdata_o (ram_rdata[g])
    );
  end

  // Selected class state
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign cnt      = free_cnt_q[cmd_i.cls];
  assign pool     = POOL_SIZE[cmd_i.cls];
  assign pop_pos  = cnt - CW'(1);
  assign push_cnt = cnt + CW'(1);
  assign grant    = !cmd_i.too_big && (cmd_i.op == scba_pkg::OP_ALLOC) && (cnt != '0);

  assign cmd_ready_o = (state_q == scba_pkg::BK_IDLE) && out_free;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign ram_raddr = pop_pos[IW-1:0];
  assign ram_waddr = cnt[IW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      scba_pkg::BK_IDLE: begin
        if (fire && grant) begin
          state_d = scba_pkg::BK_READ;
        end
      end
      scba_pkg::BK_READ: begin
        state_d = scba_pkg::BK_IDLE;
      end
      default: begin
        state_d = scba_pkg::BK_IDLE;
      end
    endcase
  end

  // Stack updates and response formation
  always_comb begin
    free_cnt_d   = free_cnt_q;
    low_d        = low_q;
    ram_we       = '0;
    pend_cls_d   = pend_cls_q;
    pend_mem_d   = pend_mem_q;
    pend_addr_d  = pend_addr_q;
    pend_used_d  = pend_used_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_gsize_d  = rsp_gsize_q;
    rsp_index_d  = rsp_index_q;
    rsp_class_d  = rsp_class_q;
    rsp_used_d   = rsp_used_q;
    case (state_q)
      scba_pkg::BK_IDLE: begin
        if (fire) begin
          rsp_gsize_d = '0;
          rsp_index_d = '0;
          rsp_class_d = cmd_i.cls;
          rsp_used_d  = '0;
          if (cmd_i.too_big) begin
            // Drop oversized requests without touching state
            rsp_valid_d  = 1'b1;
            rsp_status_d = scba_pkg::ST_TOO_BIG;
            rsp_class_d  = '0;
          end else if (cmd_i.op == scba_pkg::OP_ALLOC) begin
            if (cnt == '0) begin
              rsp_valid_d  = 1'b1;
              rsp_status_d = scba_pkg::ST_EMPTY;
              rsp_used_d   = pool;
            end else begin
              // Pop: read issued now, response formed next cycle
              free_cnt_d[cmd_i.cls] = pop_pos;
              if (pop_pos < low_q[cmd_i.cls]) begin
                low_d[cmd_i.cls] = pop_pos;
              end
              pend_cls_d  = cmd_i.cls;
              pend_mem_d  = (pop_pos >= low_q[cmd_i.cls]);
              pend_addr_d = pop_pos[IW-1:0];
              pend_used_d = pool - pop_pos;
            end
          end else begin
            rsp_valid_d = 1'b1;
            rsp_index_d = cmd_i.idx;
            if (cnt >= pool) begin
              rsp_status_d = scba_pkg::ST_REJECTED;
            end else begin
              // Push the freed index
              ram_we[cmd_i.cls]     = 1'b1;
              free_cnt_d[cmd_i.cls] = push_cnt;
              rsp_status_d          = scba_pkg::ST_FREED;
              rsp_used_d            = pool - push_cnt;
            end
          end
        end
      end
      scba_pkg::BK_READ: begin
        rsp_valid_d  = 1'b1;
        rsp_status_d = scba_pkg::ST_GRANTED;
        rsp_gsize_d  = scba_pkg::BASE_SIZE << pend_cls_q;
        rsp_index_d  = pend_mem_q ? ram_rdata[pend_cls_q] : pend_addr_q;
        rsp_class_d  = pend_cls_q;
        rsp_used_d   = pend_used_q;
      end
      default: begin
        rsp_valid_d = rsp_valid_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scba_pkg::BK_IDLE;
      rsp_valid_q <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        free_cnt_q[c] <= POOL_SIZE[c];
        low_q[c]      <= POOL_SIZE[c];
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      free_cnt_q  <= free_cnt_d;
      low_q       <= low_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_cls_q   <= pend_cls_d;
    pend_mem_q   <= pend_mem_d;
    pend_addr_q  <= pend_addr_d;
    pend_used_q  <= pend_used_d;
    rsp_status_q <= rsp_status_d;
    rsp_gsize_q  <= rsp_gsize_d;
    rsp_index_q  <= rsp_index_d;
    rsp_class_q  <= rsp_class_d;
    rsp_used_q   <= rsp_used_d;
  end

  // Drive the response channel
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.granted_size = rsp_gsize_q;
  assign rsp_o.out_index    = rsp_index_q;
  assign rsp_o.size_class   = rsp_class_q;
  assign rsp_o.used_count   = rsp_used_q;

`ifndef SYNTHESIS
  // The read cycle always finds the response slot empty
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scba_pkg::BK_READ |-> !rsp_valid_q)
    else $error("response slot busy during stack read");

  // A pop's read state is always followed by idle
  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scba_pkg::BK_READ |=> state_q == scba_pkg::BK_IDLE)
    else $error("stack read lasted more than one cycle");

  // The low mark never exceeds the free count
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q[0] <= free_cnt_q[0] && low_q[1] <= free_cnt_q[1] &&
    low_q[2] <= free_cnt_q[2] && low_q[3] <= free_cnt_q[3])
    else $error("low mark above free count");

  // Free counts stay within the pool sizes
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q[0] <= POOL_SIZE[0] && free_cnt_q[1] <= POOL_SIZE[1] &&
    free_cnt_q[2] <= POOL_SIZE[2] && free_cnt_q[3] <= POOL_SIZE[3])
    else $error("free count above pool size");

  // A grant always leaves at least one buffer in use
  a_grant_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_status_q == scba_pkg::ST_GRANTED |-> rsp_used_q != '0)
    else $error("grant reported with zero buffers in use");
`endif

endmodule

`default_nettype wire

>>> hdl/size_class_buffer_allocator_core.sv
// Top level of the size-class buffer allocator: front end, queue and back end.
//
//   channel  dir  transfer when        payload
//   req_i    in   valid && ready       op, req_size, buf_index
//   rsp_o    out  valid && ready       status, granted_size, out_index, size_class, used_count
//
// Granted allocations pass through the back end's read state (stack RAM read is registered);
// too-big, class-empty, free and rejected-free responses are registered on acceptance.
// The front end classifies in the accept cycle and buffers two requests ahead of the back end.
// Reset clears free counts to the pool sizes; the stacks need no clearing pass, since slots
// below the lowest free count seen so far read back as their own index.
// A stalled response holds the back end; the queue keeps taking requests until full.
`timescale 1ns / 1ps
`default_nettype none

module size_class_buffer_allocator_core #(
  parameter int unsigned POOL_2K  = scba_pkg::POOL_2K_DEF,
  parameter int unsigned POOL_4K  = scba_pkg::POOL_4K_DEF,
  parameter int unsigned POOL_8K  = scba_pkg::POOL_8K_DEF,
  parameter int unsigned POOL_16K = scba_pkg::POOL_16K_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  scba_req_if.sink   req_i,
  scba_rsp_if.source rsp_o
);

  logic           cmd_valid;
  logic           cmd_ready;
  scba_pkg::cmd_t cmd;

  // Accept and classify
  scba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Execute against the free stacks
  scba_back #(
    .POOL_2K  (POOL_2K),
    .POOL_4K  (POOL_4K),
    .POOL_8K  (POOL_8K),
    .POOL_16K (POOL_16K)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
